### rtl/iimb_pkg.sv
// shared types and constants for the inverse index map builder
`default_nettype none

package iimb_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int MAX_BUCKETS = 256;

  // field widths
  localparam int POS_W  = 10;
  localparam int BVAL_W = 8;
  localparam int RD_W   = 11;

  // storage widths
  localparam int ENT_AW = $clog2(MAX_ENTRIES);
  localparam int BKT_AW = $clog2(MAX_BUCKETS);
  localparam int OFF_AW = $clog2(MAX_BUCKETS + 1);
  localparam int NB_W   = $clog2(MAX_BUCKETS + 1);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 1'b1;

  typedef enum logic [1:0] {
    FUNC_WRITE    = 2'd0,
    FUNC_BUILD    = 2'd1,
    FUNC_READ_POS = 2'd2,
    FUNC_READ_OFF = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BUILT     = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_BUILT = 2'd3
  } status_t;

  typedef struct packed {
    func_t             func;
    logic [POS_W-1:0]  position;
    logic [BVAL_W-1:0] bucket_value;
  } in_item_t;

  typedef struct packed {
    logic [RD_W-1:0] read_data;
    status_t         status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RESP,
    S_CLR,
    S_CNT_F,
    S_CNT_C,
    S_CNT_W,
    S_SCAN_R,
    S_SCAN_W,
    S_SCAN_END,
    S_PL_F,
    S_PL_C,
    S_PL_W,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

### rtl/iimb_ram.sv
// generic single write port ram with registered read
`default_nettype none

module iimb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/inverse_index_map_builder.sv
// top level: forward map store, counting sort sequencer and csr offset builder
//
//  channel  ports                              handshake
//  in       start, busy, in_data               taken when start && !busy
//  out      out_valid, out_data                one-cycle strobe, no back-pressure
//  cfg      cfg_valid, cfg_ready, cfg_index,   taken when cfg_valid && cfg_ready
//           cfg_data                           (ready only while idle and start is low)
//
// write and read items pass through S_RESP, whose result is registered onto
// the strobe. a build runs a cursor clear, a count pass over entries, a prefix
// scan over buckets and a place pass over entries (fetch, compute and write per
// entry, bounded by the serial read-modify-write of the cursor ram).
// reset clears the control state and the built flag; the rams are not cleared.
// busy stays high for the whole item; results cannot be stalled by the receiver.
`default_nettype none

module inverse_index_map_builder (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire iimb_pkg::in_item_t             in_data,
  output logic                                out_valid,
  output iimb_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [iimb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [iimb_pkg::CFG_DATA_W-1:0] cfg_data
);

  import iimb_pkg::*;

  state_t state_r, state_nxt;

  logic [NB_W-1:0]   nb_r;
  logic [CNT_W-1:0]  ne_r;
  logic              built_r, built_nxt;
  func_t             func_r, func_nxt;
  status_t           stat_r, stat_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [NB_W-1:0]   bkt_r, bkt_nxt;
  logic [CNT_W-1:0]  run_r, run_nxt;
  logic [BKT_AW-1:0] k_r, k_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              accept;
  logic              last_entry;
  logic              last_bucket;
  logic [BKT_AW-1:0] k_sat;
  logic [CNT_W-1:0]  add_b;
  logic [CNT_W-1:0]  add_sum;

  // ram ports
  logic              fm_we;
  logic [ENT_AW-1:0] fm_raddr;
  logic [BVAL_W-1:0] fm_rdata;
  logic              cur_we;
  logic [BKT_AW-1:0] cur_waddr, cur_raddr;
  logic [CNT_W-1:0]  cur_wdata, cur_rdata;
  logic              sp_we;
  logic [POS_W-1:0]  sp_rdata;
  logic              off_we;
  logic [OFF_AW-1:0] off_waddr;
  logic [RD_W-1:0]   off_rdata;

  assign accept      = start && !busy;
  assign busy        = (state_r != S_IDLE);
  // registers only change with no transaction in flight or arriving
  assign cfg_ready   = !busy && !start;
  assign out_valid   = out_valid_r;
  assign out_data    = out_item_r;
  assign last_entry  = (idx_r == ne_r - CNT_W'(1));
  assign last_bucket = (bkt_r == nb_r - NB_W'(1));

  // bucket numbers at or above the bucket count fall into the last bucket
  always_comb begin
    if ({1'b0, fm_rdata} >= nb_r) begin
      k_sat = BKT_AW'(nb_r - NB_W'(1));
    end else begin
      k_sat = fm_rdata;
    end
  end

  // shared adder: cursor increment or prefix sum
  assign add_b   = (state_r == S_SCAN_W) ? run_r : CNT_W'(1);
  assign add_sum = cur_rdata + add_b;

  iimb_ram #(.WIDTH(BVAL_W), .DEPTH(MAX_ENTRIES)) u_fmap (
    .clk   (clk),
    .we    (fm_we),
    .waddr (in_data.position[ENT_AW-1:0]),
    .wdata (in_data.bucket_value),
    .raddr (fm_raddr),
    .rdata (fm_rdata)
  );

  iimb_ram #(.WIDTH(CNT_W), .DEPTH(MAX_BUCKETS)) u_cursor (
    .clk   (clk),
    .we    (cur_we),
    .waddr (cur_waddr),
    .wdata (cur_wdata),
    .raddr (cur_raddr),
    .rdata (cur_rdata)
  );

  iimb_ram #(.WIDTH(POS_W), .DEPTH(MAX_ENTRIES)) u_sorted (
    .clk   (clk),
    .we    (sp_we),
    .waddr (cur_rdata[ENT_AW-1:0]),
    .wdata (idx_r[POS_W-1:0]),
    .raddr (in_data.position[ENT_AW-1:0]),
    .rdata (sp_rdata)
  );

  iimb_ram #(.WIDTH(RD_W), .DEPTH(MAX_BUCKETS + 1)) u_offsets (
    .clk   (clk),
    .we    (off_we),
    .waddr (off_waddr),
    .wdata (run_r),
    .raddr (in_data.position[OFF_AW-1:0]),
    .rdata (off_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.func == FUNC_BUILD && !built_r) begin
            state_nxt = S_CLR;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_RESP:     state_nxt = S_IDLE;
      S_CLR:      state_nxt = last_bucket ? S_CNT_F : S_CLR;
      S_CNT_F:    state_nxt = S_CNT_C;
      S_CNT_C:    state_nxt = S_CNT_W;
      S_CNT_W:    state_nxt = last_entry ? S_SCAN_R : S_CNT_F;
      S_SCAN_R:   state_nxt = S_SCAN_W;
      S_SCAN_W:   state_nxt = last_bucket ? S_SCAN_END : S_SCAN_R;
      S_SCAN_END: state_nxt = S_PL_F;
      S_PL_F:     state_nxt = S_PL_C;
      S_PL_C:     state_nxt = S_PL_W;
      S_PL_W:     state_nxt = last_entry ? S_DONE : S_PL_F;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    built_nxt     = built_r;
    func_nxt      = func_r;
    stat_nxt      = stat_r;
    idx_nxt       = idx_r;
    bkt_nxt       = bkt_r;
    run_nxt       = run_r;
    k_nxt         = k_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    fm_we         = 1'b0;
    fm_raddr      = idx_r[ENT_AW-1:0];
    cur_we        = 1'b0;
    cur_waddr     = k_r;
    cur_wdata     = add_sum;
    cur_raddr     = k_sat;
    sp_we         = 1'b0;
    off_we        = 1'b0;
    off_waddr     = bkt_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt = in_data.func;
          stat_nxt = ST_OK;
          bkt_nxt  = '0;
          case (in_data.func)
            FUNC_WRITE: begin
              if (CNT_W'(in_data.position) >= ne_r) begin
                stat_nxt = ST_RANGE;
              end else begin
                fm_we = 1'b1;
              end
            end
            FUNC_BUILD: begin
              if (built_r) begin
                stat_nxt = ST_BUILT;
              end
            end
            FUNC_READ_POS: begin
              if (!built_r) begin
                stat_nxt = ST_NOT_BUILT;
              end else if (CNT_W'(in_data.position) >= ne_r) begin
                stat_nxt = ST_RANGE;
              end
            end
            FUNC_READ_OFF: begin
              if (!built_r) begin
                stat_nxt = ST_NOT_BUILT;
              end else if (CNT_W'(in_data.position) > CNT_W'(nb_r)) begin
                stat_nxt = ST_RANGE;
              end
            end
            default: stat_nxt = ST_OK;
          endcase
        end
      end
      S_RESP: begin
        out_valid_nxt          = 1'b1;
        out_item_nxt.status    = stat_r;
        out_item_nxt.read_data = '0;
        if (stat_r == ST_OK) begin
          if (func_r == FUNC_READ_POS) begin
            out_item_nxt.read_data = RD_W'(sp_rdata);
          end else if (func_r == FUNC_READ_OFF) begin
            out_item_nxt.read_data = off_rdata;
          end
        end
      end
      S_CLR: begin
        cur_we    = 1'b1;
        cur_waddr = bkt_r[BKT_AW-1:0];
        cur_wdata = '0;
        bkt_nxt   = bkt_r + NB_W'(1);
        idx_nxt   = '0;
      end
      S_CNT_C, S_PL_C: begin
        k_nxt = k_sat;
      end
      S_CNT_W: begin
        cur_we  = 1'b1;
        idx_nxt = idx_r + CNT_W'(1);
        bkt_nxt = '0;
        run_nxt = '0;
      end
      S_SCAN_R: begin
        cur_raddr = bkt_r[BKT_AW-1:0];
      end
      S_SCAN_W: begin
        // offset and cursor both take the running start of this bucket
        off_we    = 1'b1;
        cur_we    = 1'b1;
        cur_waddr = bkt_r[BKT_AW-1:0];
        cur_wdata = run_r;
        run_nxt   = add_sum;
        bkt_nxt   = bkt_r + NB_W'(1);
      end
      S_SCAN_END: begin
        off_we  = 1'b1;
        idx_nxt = '0;
      end
      S_PL_W: begin
        sp_we   = 1'b1;
        cur_we  = 1'b1;
        idx_nxt = idx_r + CNT_W'(1);
      end
      S_DONE: begin
        built_nxt              = 1'b1;
        out_valid_nxt          = 1'b1;
        out_item_nxt.status    = ST_OK;
        out_item_nxt.read_data = '0;
      end
      default: begin
        built_nxt = built_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
      nb_r        <= NB_W'(MAX_BUCKETS);
      ne_r        <= CNT_W'(MAX_ENTRIES);
    end else begin
      state_r     <= state_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt;
      // register writes are locked once the inverse map exists
      if (cfg_valid && cfg_ready && !built_r) begin
        if (cfg_index == CFG_BUCKET_COUNT) begin
          if (cfg_data[NB_W-1:0] == '0) begin
            nb_r <= NB_W'(1);
          end else if (cfg_data[NB_W-1:0] > NB_W'(MAX_BUCKETS)) begin
            nb_r <= NB_W'(MAX_BUCKETS);
          end else begin
            nb_r <= cfg_data[NB_W-1:0];
          end
        end else if (cfg_index == CFG_ENTRY_COUNT) begin
          if (cfg_data[CNT_W-1:0] == '0) begin
            ne_r <= CNT_W'(1);
          end else if (cfg_data[CNT_W-1:0] > CNT_W'(MAX_ENTRIES)) begin
            ne_r <= CNT_W'(MAX_ENTRIES);
          end else begin
            ne_r <= cfg_data[CNT_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    stat_r     <= stat_nxt;
    idx_r      <= idx_nxt;
    bkt_r      <= bkt_nxt;
    run_r      <= run_nxt;
    k_r        <= k_nxt;
    out_item_r <= out_item_nxt;
  end

  // a result strobe always closes a busy period
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  // non-build transactions answer from S_RESP through the registered strobe
  a_short_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.func != FUNC_BUILD) |=> ##1 out_valid)
    else $error("write or read transaction did not answer in two cycles");

  // only reset clears the built flag
  a_built_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(built_r)) |-> built_r)
    else $error("inverse built flag dropped without reset");

endmodule

`default_nettype wire

### dv/tb_top.sv
// testbench for the inverse index map builder: entry writes, one csr build, checked reads
module tb_top;
  import iimb_pkg::*;

  // tracks the forward map, the sorted positions and the csr offsets the block should hold
  class csr_map_model;
    logic [BVAL_W-1:0] fwd_map [MAX_ENTRIES];
    logic [POS_W-1:0]  sorted_pos [MAX_ENTRIES];
    logic [RD_W-1:0]   offsets [MAX_BUCKETS+1];
    bit                built;
    logic [8:0]        bucket_reg;
    logic [10:0]       entry_reg;
    out_item_t         pending_q [$];
    int                fails;
    int                checked;

    function new();
      built      = 1'b0;
      bucket_reg = 9'd256;
      entry_reg  = 11'd1024;
      fails      = 0;
      checked    = 0;
      foreach (fwd_map[i]) fwd_map[i] = '0;
      foreach (sorted_pos[i]) sorted_pos[i] = '0;
      foreach (offsets[i]) offsets[i] = '0;
    endfunction

    // zero acts as one, anything above the maximum acts as the maximum
    function int clamp(int v, int mx);
      if (v == 0) return 1;
      return (v > mx) ? mx : v;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (built) return;
      if (idx == CFG_BUCKET_COUNT) bucket_reg = data[8:0];
      else entry_reg = data;
    endfunction

    function int bucket_of(int i, int nb);
      int k;
      k = fwd_map[i];
      return (k >= nb) ? nb - 1 : k;
    endfunction

    function void sort_entries();
      int nb;
      int ne;
      int run;
      int c;
      int k;
      int cursor [MAX_BUCKETS+1];
      nb = clamp(bucket_reg, MAX_BUCKETS);
      ne = clamp(entry_reg, MAX_ENTRIES);
      foreach (cursor[b]) cursor[b] = 0;
      for (int i = 0; i < ne; i++) cursor[bucket_of(i, nb)]++;
      run = 0;
      for (int b = 0; b < nb; b++) begin
        offsets[b] = run[RD_W-1:0];
        c = cursor[b];
        cursor[b] = run;
        run += c;
      end
      offsets[nb] = run[RD_W-1:0];
      // second pass keeps position order inside each bucket
      for (int i = 0; i < ne; i++) begin
        k = bucket_of(i, nb);
        sorted_pos[cursor[k]] = i[POS_W-1:0];
        cursor[k]++;
      end
      built = 1'b1;
    endfunction

    function void note_item(in_item_t it);
      out_item_t r;
      int nb;
      int ne;
      int pos;
      r.read_data = '0;
      r.status    = ST_OK;
      nb  = clamp(bucket_reg, MAX_BUCKETS);
      ne  = clamp(entry_reg, MAX_ENTRIES);
      pos = it.position;
      case (it.func)
        FUNC_WRITE: begin
          if (pos >= ne) r.status = ST_RANGE;
          else fwd_map[pos] = it.bucket_value;
        end
        FUNC_BUILD: begin
          if (built) r.status = ST_BUILT;
          else sort_entries();
        end
        FUNC_READ_POS: begin
          // not-built check wins over the range check
          if (!built) r.status = ST_NOT_BUILT;
          else if (pos >= ne) r.status = ST_RANGE;
          else r.read_data = {1'b0, sorted_pos[pos]};
        end
        FUNC_READ_OFF: begin
          if (!built) r.status = ST_NOT_BUILT;
          else if (pos > nb) r.status = ST_RANGE;
          else r.read_data = offsets[pos];
        end
      endcase
      pending_q.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_q.size() == 0) begin
        fails++;
        $display("%0t: unexpected result: read_data %0d status %0d",
                 $time, got.read_data, got.status);
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (got.read_data !== want.read_data) begin
        fails++;
        $display("%0t: read_data mismatch: expected %0d actual %0d",
                 $time, want.read_data, got.read_data);
      end
      if (got.status !== want.status) begin
        fails++;
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, want.status, got.status);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_data = '0;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  csr_map_model map_model = new();
  bit no_gaps = 1'b0;
  int nb_eff;
  int ne_eff;

  inverse_index_map_builder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) map_model.check_result(out_data);
      if (start && !busy) map_model.note_item(in_data);
      if (cfg_valid && cfg_ready) map_model.note_config(cfg_index, cfg_data);
    end
  end

  // start stays high across back-to-back transactions; this task lowers it only for a gap
  task automatic issue(func_t f, int pos, int val);
    in_item_t it;
    int gap;
    it.func         = f;
    it.position     = pos[POS_W-1:0];
    it.bucket_value = val[BVAL_W-1:0];
    if ($urandom_range(0, 31) == 0) no_gaps = !no_gaps;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic quiesce();
    start <= 1'b0;
    while (map_model.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  // mostly valid buckets, some values past bucket_count to hit saturation
  function automatic int pick_bucket(int nb);
    case ($urandom_range(0, 7))
      0: return 255;
      1: return 0;
      2: return $urandom_range(0, 255);
      default: return $urandom_range(0, nb - 1);
    endcase
  endfunction

  initial begin
    int bsel;
    int esel;
    int sel;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reads before the build, writes at the field extremes
    issue(FUNC_READ_POS, 0, 0);
    issue(FUNC_READ_POS, 1023, 255);
    issue(FUNC_READ_OFF, 1023, 0);
    issue(FUNC_READ_OFF, 0, 0);
    issue(FUNC_WRITE, 0, 255);
    issue(FUNC_WRITE, 1023, 0);
    issue(FUNC_WRITE, 10'h2AA, 8'h55);
    issue(FUNC_WRITE, 10'h155, 8'hAA);
    quiesce();
    write_reg(CFG_ENTRY_COUNT, 0);
    write_reg(CFG_BUCKET_COUNT, 0);
    issue(FUNC_WRITE, 1, 3);
    issue(FUNC_WRITE, 0, 7);
    quiesce();
    write_reg(CFG_ENTRY_COUNT, 2047);
    write_reg(CFG_BUCKET_COUNT, 511);
    issue(FUNC_WRITE, 1023, 200);
    quiesce();
    write_reg(CFG_ENTRY_COUNT, 1);
    issue(FUNC_WRITE, 0, 1);
    issue(FUNC_WRITE, 1, 1);
    quiesce();
    write_reg(CFG_ENTRY_COUNT, 1025);
    issue(FUNC_WRITE, 1023, 9);
    issue(FUNC_READ_OFF, 257, 0);

    // unbuilt phase noise under changing limits, never a build
    for (int k = 0; k < 100; k++) begin
      if (k % 25 == 0) begin
        quiesce();
        write_reg(CFG_BUCKET_COUNT, $urandom_range(0, 511));
        write_reg(CFG_ENTRY_COUNT, $urandom_range(0, 2047));
      end
      sel = $urandom_range(0, 3);
      issue(sel == 0 ? FUNC_READ_POS : (sel == 1 ? FUNC_READ_OFF : FUNC_WRITE),
            $urandom_range(0, 1023), $urandom_range(0, 255));
    end

    // limits for the one build of the run
    quiesce();
    case ($urandom_range(0, 5))
      0: bsel = 0;
      1: bsel = 1;
      2: bsel = 256;
      3: bsel = 511;
      default: bsel = $urandom_range(2, 64);
    endcase
    case ($urandom_range(0, 7))
      0: esel = 1024;
      1: esel = 0;
      2: esel = 1;
      default: esel = $urandom_range(2, 300);
    endcase
    nb_eff = map_model.clamp(bsel, MAX_BUCKETS);
    ne_eff = map_model.clamp(esel, MAX_ENTRIES);
    write_reg(CFG_BUCKET_COUNT, bsel);
    write_reg(CFG_ENTRY_COUNT, esel);

    // every entry in use gets written before the build
    for (int k = 0; k < ne_eff; k++) issue(FUNC_WRITE, k, pick_bucket(nb_eff));
    repeat (ne_eff / 8) issue(FUNC_WRITE, $urandom_range(0, ne_eff - 1), pick_bucket(nb_eff));
    if (ne_eff < MAX_ENTRIES)
      repeat (4) issue(FUNC_WRITE, $urandom_range(ne_eff, 1023), $urandom_range(0, 255));

    issue(FUNC_BUILD, $urandom_range(0, 1023), $urandom_range(0, 255));
    issue(FUNC_BUILD, $urandom_range(0, 1023), $urandom_range(0, 255));

    // registers are locked once built
    quiesce();
    write_reg(CFG_BUCKET_COUNT, 1);
    write_reg(CFG_ENTRY_COUNT, 2047);

    issue(FUNC_READ_OFF, 0, 0);
    issue(FUNC_READ_OFF, nb_eff, 0);
    issue(FUNC_READ_OFF, nb_eff + 1, 0);
    issue(FUNC_READ_OFF, 1023, 0);
    issue(FUNC_READ_POS, 0, 0);
    issue(FUNC_READ_POS, ne_eff - 1, 0);
    if (ne_eff < MAX_ENTRIES) issue(FUNC_READ_POS, ne_eff, 0);
    issue(FUNC_READ_POS, 1023, 0);

    for (int k = 0; k < 200; k++) begin
      if (k % 100 == 99) begin
        quiesce();
        write_reg(CFG_BUCKET_COUNT, $urandom_range(0, 511));
        write_reg(CFG_ENTRY_COUNT, $urandom_range(0, 2047));
      end
      sel = $urandom_range(0, 19);
      if (sel < 7) issue(FUNC_READ_POS, $urandom_range(0, ne_eff - 1), $urandom_range(0, 255));
      else if (sel < 14) issue(FUNC_READ_OFF, $urandom_range(0, nb_eff), $urandom_range(0, 255));
      else if (sel < 17) issue(FUNC_WRITE, $urandom_range(0, 1023), $urandom_range(0, 255));
      else if (sel == 17) issue(FUNC_BUILD, $urandom_range(0, 1023), $urandom_range(0, 255));
      else if (sel == 18) issue(FUNC_READ_POS, $urandom_range(0, 1023), $urandom_range(0, 255));
      else issue(FUNC_READ_OFF, $urandom_range(0, 1023), $urandom_range(0, 255));
    end

    start <= 1'b0;
    while (map_model.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("tb_top: %0d results compared; build over %0d entries into %0d buckets",
             map_model.checked, ne_eff, nb_eff);
    if (map_model.fails == 0 && map_model.pending_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

### sim.f
rtl/iimb_pkg.sv
rtl/iimb_ram.sv
rtl/inverse_index_map_builder.sv
dv/tb_top.sv
